// ===== rtl/core/dpgs_pkg.sv =====
// dpgs_pkg: shared field widths and item mode codes for the deadline
// priority grant scheduler. No dependencies.
package dpgs_pkg;

  // fixed payload widths of the request and grant channels
  localparam int MODE_W = 2;
  localparam int ID_W   = 6;
  localparam int DL_W   = 16;

  // input item modes
  localparam logic [MODE_W-1:0] MODE_ARRIVE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

endpackage

// ===== rtl/core/dpgs_if.sv =====
// dpgs_req_if / dpgs_grant_if: valid/ready channels of the scheduler.
// Depends on dpgs_pkg for the payload widths.
interface dpgs_req_if;
  import dpgs_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   request_id;
  logic [DL_W-1:0]   deadline;

  modport source (output valid, mode, request_id, deadline, input ready);
  modport sink   (input valid, mode, request_id, deadline, output ready);
endinterface

interface dpgs_grant_if;
  import dpgs_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] granted_id;
  logic [DL_W-1:0] grant_time;

  modport source (output valid, granted_id, grant_time, input ready);
  modport sink   (input valid, granted_id, grant_time, output ready);
endinterface

// ===== rtl/core/deadline_priority_grant_scheduler.sv =====
// deadline_priority_grant_scheduler: request table in one synchronous memory,
// scanned once per tick. Depends on dpgs_pkg and dpgs_if.sv.
//
// Each of the NUM_REQ table entries holds a pending bit and a deadline in one
// memory word. An arrive is a single write. In a tick the table is read one
// entry per cycle through the memory's single read port, and each entry is
// written back in the cycle after its read with the grant and expiry applied,
// so the scan length is set by that one read port. The grant, if any, goes
// into an output register; a further tick can start while it waits, and
// holds at its end until the register is free. A clear item, and likewise
// the pass that follows reset, sweeps the table once to clear the pending
// bits, during which no item is taken.
module deadline_priority_grant_scheduler #(
  parameter int NUM_REQ   = 64,
  parameter int TIME_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  dpgs_req_if.sink            req,
  dpgs_grant_if.source        grant
);
  import dpgs_pkg::*;

  localparam int IDX_W = $clog2(NUM_REQ);
  localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(NUM_REQ - 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  // table memory: msb is the pending bit, the rest the deadline
  logic [TIME_BITS:0] mem [NUM_REQ];
  logic [TIME_BITS:0] rd_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [TIME_BITS:0] wr_data;

  logic [1:0]           state;
  logic [IDX_W-1:0]     cnt;
  logic                 issuing;
  logic                 rd_v;
  logic [IDX_W-1:0]     rd_a;
  logic                 found;
  logic [IDX_W-1:0]     gid;
  logic [TIME_BITS-1:0] now;
  logic                 out_valid;
  logic [ID_W-1:0]      out_id;
  logic [DL_W-1:0]      out_time;

  logic                    accept;
  logic                    id_ok;
  logic [ID_W+IDX_W-1:0]   req_id_wide;
  logic [ID_W+IDX_W-1:0]   gid_wide;
  logic [DL_W+TIME_BITS-1:0] dl_wide;
  logic [DL_W+TIME_BITS-1:0] now_wide;
  logic                    ent_pend;
  logic [TIME_BITS-1:0]    ent_due;
  logic                    take;
  logic                    keep;
  logic                    load_out;

  assign accept      = req.valid && req.ready;
  assign req.ready   = (state == ST_IDLE);
  assign req_id_wide = {{IDX_W{1'b0}}, req.request_id};
  assign gid_wide    = {{ID_W{1'b0}}, gid};
  assign dl_wide     = {{TIME_BITS{1'b0}}, req.deadline};
  assign now_wide    = {{DL_W{1'b0}}, now};
  assign id_ok       = (32'(req.request_id) < 32'(NUM_REQ));

  // entry under inspection during a scan
  assign ent_pend = rd_data[TIME_BITS];
  assign ent_due  = rd_data[TIME_BITS-1:0];
  assign take     = ent_pend && (ent_due >= now) && !found;
  assign keep     = ent_pend && (ent_due > now) && found;

  // grant moves into the output register at the end of a scan
  assign load_out = (state == ST_FINISH) && found && (!out_valid || grant.ready);

  // memory port control
  always_comb begin
    rd_en   = (state == ST_SCAN) && issuing;
    rd_addr = cnt;
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = '0;
    unique case (state)
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ST_IDLE: begin
        wr_en   = accept && (req.mode == MODE_ARRIVE) && id_ok;
        wr_addr = req_id_wide[IDX_W-1:0];
        wr_data = {1'b1, dl_wide[TIME_BITS-1:0]};
      end
      ST_SCAN: begin
        wr_en   = rd_v;
        wr_addr = rd_a;
        wr_data = {keep, ent_due};
      end
      ST_FINISH: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // sequencer: clearing sweep, idle, tick scan, grant hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      issuing   <= 1'b0;
      rd_v      <= 1'b0;
      found     <= 1'b0;
      now       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && grant.ready && !load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (cnt == LAST_IDX) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (req.mode == MODE_TICK) begin
              if (now != TIME_MAX) begin
                now <= now + 1'b1;
              end
              cnt     <= '0;
              issuing <= 1'b1;
              rd_v    <= 1'b0;
              found   <= 1'b0;
              state   <= ST_SCAN;
            end else if (req.mode == MODE_CLEAR) begin
              now   <= '0;
              cnt   <= '0;
              state <= ST_CLEAR;
            end
          end
        end
        ST_SCAN: begin
          rd_v <= issuing;
          rd_a <= cnt;
          if (issuing) begin
            cnt <= cnt + 1'b1;
            if (cnt == LAST_IDX) begin
              issuing <= 1'b0;
            end
          end
          if (rd_v) begin
            if (take) begin
              found <= 1'b1;
              gid   <= rd_a;
            end
            if (rd_a == LAST_IDX) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (!found) begin
            state <= ST_IDLE;
          end else if (load_out) begin
            out_valid <= 1'b1;
            out_id    <= gid_wide[ID_W-1:0];
            out_time  <= now_wide[DL_W-1:0];
            found     <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  assign grant.valid      = out_valid;
  assign grant.granted_id = out_id;
  assign grant.grant_time = out_time;

endmodule

// ===== rtl/core/dpgs_checker.sv =====
// dpgs_checker: port-level checks for the scheduler, bound to its top level.
// Depends on dpgs_pkg and deadline_priority_grant_scheduler.
module dpgs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic [dpgs_pkg::MODE_W-1:0]  req_mode,
  input logic                         grant_valid,
  input logic                         grant_ready,
  input logic [dpgs_pkg::ID_W-1:0]    granted_id,
  input logic [dpgs_pkg::DL_W-1:0]    grant_time
);
  import dpgs_pkg::*;

  logic req_xfer;
  assign req_xfer = req_valid && req_ready;

  // a stalled grant keeps its payload
  a_grant_hold: assert property (@(posedge clk) disable iff (rst)
    (grant_valid && !grant_ready) |=> (grant_valid && $stable(granted_id)
      && $stable(grant_time)))
    else $error("grant payload changed while stalled");

  // the clearing sweep after reset takes no item
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("item taken during clearing sweep");

  // a clear transfer starts a sweep
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (req_xfer && req_mode == MODE_CLEAR) |=> !req_ready)
    else $error("clear did not start a sweep");

  // after an arrive the request channel is ready again in the next cycle
  a_arrive_fast: assert property (@(posedge clk) disable iff (rst)
    (req_xfer && req_mode == MODE_ARRIVE) |=> req_ready)
    else $error("arrive held the request channel");

  // a tick cannot produce a grant in the very next cycle
  a_tick_latency: assert property (@(posedge clk) disable iff (rst)
    (req_xfer && req_mode == MODE_TICK) |=> !$rose(grant_valid))
    else $error("grant appeared before the scan finished");

endmodule

bind deadline_priority_grant_scheduler dpgs_checker u_dpgs_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_mode    (req.mode),
  .grant_valid (grant.valid),
  .grant_ready (grant.ready),
  .granted_id  (grant.granted_id),
  .grant_time  (grant.grant_time)
);

// ===== test/deadline_priority_grant_scheduler_tb.sv =====
`timescale 1ns / 1ps
// deadline_priority_grant_scheduler_tb: arrive, tick and clear transfers checked against
// a behavioral copy of the request table. Depends on dpgs_pkg, dpgs_if.sv and the RTL.
module deadline_priority_grant_scheduler_tb;
  import dpgs_pkg::*;

  localparam int                NUM_REQ      = 64;
  localparam logic [MODE_W-1:0] MODE_NOP     = 2'd3;
  localparam logic [DL_W-1:0]   TICK_MAX     = '1;
  localparam int                RANDOM_ITEMS = 1780;
  localparam int                HOLD_CYCLES  = 600;
  localparam int                IDLE_LIMIT   = 5000;
  localparam int                DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [DL_W-1:0] at_tick;
  } grant_t;

  // one request-channel transfer; known rows carry a grant typed in by hand
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   id;
    logic [DL_W-1:0]   dl;
    logic              known;
    grant_t            want;
  } item_t;

  logic clk = 1'b0;
  logic rst;

  dpgs_req_if   req_ch ();
  dpgs_grant_if grant_ch ();

  deadline_priority_grant_scheduler #(
    .NUM_REQ  (NUM_REQ),
    .TIME_BITS(DL_W)
  ) uut (
    .clk  (clk),
    .rst  (rst),
    .req  (req_ch),
    .grant(grant_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // request table as the scheduler should hold it
  logic            pend_flag [NUM_REQ];
  logic [DL_W-1:0] due_tick  [NUM_REQ];
  logic [DL_W-1:0] now_tick;
  grant_t          pending_grants [$];

  int fail_count  = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  bit hold_req    = 1'b0;
  bit send_quiet  = 1'b0;
  bit recv_quiet  = 1'b0;

  // apply one transfer to the table; returns 1 when a tick grants
  function automatic bit schedule_step(input item_t it, output grant_t g);
    bit hit;
    hit = 1'b0;
    g   = '0;
    case (it.mode)
      MODE_ARRIVE: begin
        pend_flag[it.id] = 1'b1;
        due_tick[it.id]  = it.dl;
      end
      MODE_CLEAR: begin
        foreach (pend_flag[k]) pend_flag[k] = 1'b0;
        now_tick = '0;
      end
      MODE_TICK: begin
        if (now_tick != TICK_MAX) now_tick = now_tick + 1'b1;
        // lowest id still within its deadline wins
        for (int k = 0; k < NUM_REQ; k++) begin
          if (!hit && pend_flag[k] && due_tick[k] >= now_tick) begin
            pend_flag[k] = 1'b0;
            g.id         = k[ID_W-1:0];
            g.at_tick    = now_tick;
            hit          = 1'b1;
          end
        end
        // expiry after the grant
        for (int k = 0; k < NUM_REQ; k++) begin
          if (pend_flag[k] && due_tick[k] <= now_tick) pend_flag[k] = 1'b0;
        end
      end
      default: ;
    endcase
    return hit;
  endfunction

  function automatic item_t mk_item(input logic [MODE_W-1:0] mode, input int id,
                                    input int dl, input bit known = 1'b0,
                                    input int gid = 0, input int gtick = 0);
    item_t it;
    it.mode         = mode;
    it.id           = id[ID_W-1:0];
    it.dl           = dl[DL_W-1:0];
    it.known        = known;
    it.want.id      = gid[ID_W-1:0];
    it.want.at_tick = gtick[DL_W-1:0];
    return it;
  endfunction

  // mostly deadlines a little ahead of now, some already past, some anywhere
  function automatic item_t random_item();
    logic [DL_W:0]     sum;
    logic [DL_W-1:0]   dl;
    logic [MODE_W-1:0] mode;
    int                id;
    int                r;
    r = $urandom_range(0, 199);
    if (r < 90) mode = MODE_ARRIVE;
    else if (r < 182) mode = MODE_TICK;
    else if (r < 185) mode = MODE_CLEAR;
    else mode = MODE_NOP;
    id = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
    r  = $urandom_range(0, 99);
    if (r < 70) begin
      sum = {1'b0, now_tick} + (DL_W+1)'($urandom_range(0, 24));
      dl  = sum[DL_W] ? TICK_MAX : sum[DL_W-1:0];
    end else if (r < 80) begin
      dl = (now_tick > 3) ? now_tick - DL_W'($urandom_range(1, 3)) : '0;
    end else begin
      dl = DL_W'($urandom_range(0, 65535));
    end
    return mk_item(mode, id, int'(dl));
  endfunction

  // offer one transfer, wait for it to be taken, then update the table
  task automatic send_item(input item_t it);
    int     gap;
    bit     hit;
    grant_t g;
    gap = (send_quiet || burst_left > 0) ? 0 : $urandom_range(0, 14);
    if (burst_left > 0) burst_left--;
    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.mode       <= it.mode;
    req_ch.request_id <= it.id;
    req_ch.deadline   <= it.dl;
    req_ch.valid      <= 1'b1;
    do @(posedge clk); while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
    hit = schedule_step(it, g);
    if (it.known) pending_grants.insert(pending_grants.size(), it.want);
    else if (hit) pending_grants.insert(pending_grants.size(), g);
    @(negedge clk);
  endtask

  task automatic note_mismatch(input string what, input grant_t want, input grant_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s: expected id %0d tick %0d, got id %0d tick %0d", $realtime,
               what, want.id, want.at_tick, got.id, got.at_tick);
  endtask

  // grant channel ready, with random stalls and one long hold-off on request
  initial begin : grant_sink
    int gap;
    grant_ch.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = recv_quiet ? 0 : $urandom_range(0, 14);
      end
      if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
      if (gap > 0) begin
        grant_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      grant_ch.ready <= 1'b1;
      do @(posedge clk); while (!(grant_ch.valid === 1'b1 && grant_ch.ready === 1'b1));
      @(negedge clk);
    end
  end

  // compare each grant transfer with the oldest expected grant
  always @(posedge clk) begin : grant_check
    grant_t got;
    grant_t want;
    if (!rst && grant_ch.valid === 1'b1 && grant_ch.ready === 1'b1) begin
      got.id      = grant_ch.granted_id;
      got.at_tick = grant_ch.grant_time;
      if (pending_grants.size() == 0) begin
        note_mismatch("grant with none expected", '0, got);
      end else begin
        want = pending_grants.pop_front();
        if (got.id !== want.id) note_mismatch("granted_id", want, got);
        else if (got.at_tick !== want.at_tick) note_mismatch("grant_time", want, got);
      end
    end
  end

  // stall watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (grant_ch.valid === 1'b1 && grant_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    item_t dir_rows [$];
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.mode       = MODE_ARRIVE;
    req_ch.request_id = '0;
    req_ch.deadline   = '0;
    foreach (pend_flag[k]) begin
      pend_flag[k] = 1'b0;
      due_tick[k]  = '0;
    end
    now_tick = '0;

    // directed rows: empty tick, priority, past deadline, overwrite, expiry, clear
    dir_rows.insert(dir_rows.size(), mk_item(MODE_TICK,   0,  0));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_ARRIVE, 63, 'hFFFF));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_ARRIVE, 0,  2));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_TICK,   0,  0, 1'b1, 0, 2));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_ARRIVE, 5,  1));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_TICK,   0,  0, 1'b1, 63, 3));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_TICK,   0,  0));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_ARRIVE, 10, 100));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_ARRIVE, 10, 5));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_ARRIVE, 20, 5));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_ARRIVE, 30, 6));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_TICK,   0,  0, 1'b1, 10, 5));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_TICK,   0,  0, 1'b1, 30, 6));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_NOP,    63, 'hFFFF));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_ARRIVE, 42, 'h5555));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_ARRIVE, 21, 'hAAAA));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_TICK,   0,  0, 1'b1, 21, 7));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_TICK,   0,  0, 1'b1, 42, 8));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_CLEAR,  0,  0));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_ARRIVE, 7,  0));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_TICK,   0,  0));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_ARRIVE, 1,  2));
    dir_rows.insert(dir_rows.size(), mk_item(MODE_TICK,   0,  0, 1'b1, 1, 2));

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i]);

    // random traffic
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      item_t it;
      if (k == 600) begin
        hold_req   = 1'b1;
        burst_left = 24;
      end
      if (k == 1200) begin
        req_ch.valid <= 1'b0;
        wait (pending_grants.size() == 0);
        @(negedge clk);
      end
      it = random_item();
      send_item(it);
    end

    req_ch.valid <= 1'b0;
    wait (pending_grants.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    fail_count += pending_grants.size();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
